// ===== sv/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // Byte classes seen while no sequence is open.
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MIN   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX   = 8'hF4;

  // Continuation bytes carry the marker 10 in their top two bits.
  localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;

  // Smallest legal value for each sequence length, and the top of Unicode.
  localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

  // Total length of the open sequence.
  typedef enum logic [2:0] {
    SEQ_NONE  = 3'd0,
    SEQ_TWO   = 3'd2,
    SEQ_THREE = 3'd3,
    SEQ_FOUR  = 3'd4
  } seq_len_t;

  // One decode outcome handed from the decoder to the result register.
  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
    logic            illegal;
  } dec_res_t;

endpackage

// ===== sv/utf8_to_code_point_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Decodes UTF-8 into Unicode code points, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ----------------------------------
//   input    in_valid / in_stall     in_byte (8 bits)
//   output   out_valid / out_stall   code_point (21 bits), illegal
//
// The decoder takes one byte every cycle while the output side keeps up.
// A byte goes from the input register through the decode logic into the
// result register, which holds each result on the output until it is taken.
// Lead bytes and continuation bytes that do not finish a character give no
// result and simply advance the sequence state.
// Reset is synchronous and active high; it empties both registers and
// returns the decoder to the idle state with no sequence open.
// A stall on the output holds the result and backs up into in_stall only
// when the input register also holds a byte that cannot move on.
//
// Behavior in brief: ASCII passes through, leads 0xC0-0xDF, 0xE0-0xEF and
// 0xF0-0xF4 open two, three and four byte sequences, and each continuation
// adds six bits. Stray continuations, leads above 0xF4, broken sequences,
// overlong forms and values above 0x10FFFF give a result with illegal set
// and a zero code point. A byte that breaks a sequence is consumed and does
// not open a new one. Surrogate values are passed as ordinary characters.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CP_W-1:0]   code_point,
  output logic              illegal
);

  logic              full;
  logic              take;
  logic [BYTE_W-1:0] held_byte;
  dec_res_t          res;

  // Input register: one byte waits here for the decode step.
  utf8d_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .take      (take),
    .full      (full),
    .held_byte (held_byte)
  );

  // Decode step: updates the sequence state whenever a byte is taken.
  utf8d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .held_byte (held_byte),
    .res       (res)
  );

  // Result register: a byte is taken only when there is room for its result.
  utf8d_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .full       (full),
    .res        (res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .illegal    (illegal)
  );

endmodule

// ===== sv/utf8d_in_reg.sv =====
// ----------------------------------------------------------------------------
// utf8d_in_reg
// Input register of the decoder: holds one byte until the decoder takes it.
// ----------------------------------------------------------------------------
module utf8d_in_reg
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              take,
  output logic              full,
  output logic [BYTE_W-1:0] held_byte
);

  logic accept;

  // A held byte that is not taken this cycle blocks the next one.
  assign in_stall = full & ~take;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= accept | (full & ~take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ===== sv/utf8d_decode.sv =====
// ----------------------------------------------------------------------------
// utf8d_decode
// Sequence state and the single-pass decode of one byte against it.
// ----------------------------------------------------------------------------
module utf8d_decode
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] held_byte,
  output dec_res_t          res
);

  logic [1:0]      pending;
  logic [1:0]      pending_next;
  logic [CP_W-1:0] partial;
  logic [CP_W-1:0] partial_next;
  seq_len_t        seq_len;
  seq_len_t        seq_len_next;

  logic [BYTE_W-1:0] payload;
  logic [CP_W-1:0]   shifted;
  logic              bad;

  assign payload = held_byte ^ CONT_MARK;
  assign shifted = {partial[CP_W-7:0], payload[5:0]};

  always_comb begin
    res          = '0;
    pending_next = pending;
    partial_next = partial;
    seq_len_next = seq_len;
    bad          = 1'b0;
    if (pending == 2'd0) begin
      if (held_byte < ASCII_LIMIT) begin
        res.emit       = 1'b1;
        res.code_point = {{(CP_W-BYTE_W){1'b0}}, held_byte};
      end else if (held_byte < LEAD2_MIN) begin
        res.emit    = 1'b1;
        res.illegal = 1'b1;
      end else if (held_byte < LEAD3_MIN) begin
        partial_next = {{(CP_W-5){1'b0}}, held_byte[4:0]};
        seq_len_next = SEQ_TWO;
        pending_next = 2'd1;
      end else if (held_byte < LEAD4_MIN) begin
        partial_next = {{(CP_W-4){1'b0}}, held_byte[3:0]};
        seq_len_next = SEQ_THREE;
        pending_next = 2'd2;
      end else if (held_byte <= LEAD4_MAX) begin
        partial_next = {{(CP_W-3){1'b0}}, held_byte[2:0]};
        seq_len_next = SEQ_FOUR;
        pending_next = 2'd3;
      end else begin
        res.emit    = 1'b1;
        res.illegal = 1'b1;
      end
    end else if (payload[7:6] != 2'b00) begin
      // Not a continuation: drop the sequence and consume this byte.
      res.emit     = 1'b1;
      res.illegal  = 1'b1;
      pending_next = 2'd0;
      partial_next = '0;
      seq_len_next = SEQ_NONE;
    end else if (pending != 2'd1) begin
      partial_next = shifted;
      pending_next = pending - 2'd1;
    end else begin
      case (seq_len)
        SEQ_TWO:   bad = shifted < MIN_TWO;
        SEQ_THREE: bad = shifted < MIN_THREE;
        default:   bad = (shifted < MIN_FOUR) || (shifted > CP_MAX);
      endcase
      res.emit       = 1'b1;
      res.illegal    = bad;
      res.code_point = bad ? '0 : shifted;
      pending_next   = 2'd0;
      partial_next   = '0;
      seq_len_next   = SEQ_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= '0;
      seq_len <= SEQ_NONE;
    end else if (take) begin
      pending <= pending_next;
      partial <= partial_next;
      seq_len <= seq_len_next;
    end
  end

endmodule

// ===== sv/utf8d_out_reg.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register of the decoder with its valid and stall handshake.
// ----------------------------------------------------------------------------
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            full,
  input  dec_res_t        res,
  output logic            take,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] code_point,
  output logic            illegal
);

  logic free;
  logic load;

  // The register is free when empty or when its result leaves this cycle.
  assign free = ~out_valid | ~out_stall;
  assign take = full & free;
  assign load = take & res.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point <= res.code_point;
      illegal    <= res.illegal;
    end
  end

endmodule

// ===== sv/utf8d_chk.sv =====
// ----------------------------------------------------------------------------
// utf8d_chk
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_chk
  import utf8d_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [BYTE_W-1:0] in_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CP_W-1:0]   code_point,
  input logic              illegal
);

  // A result held back by a stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(illegal))
    else $error("stalled result changed");

  // An error result always carries a zero code point.
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> code_point == '0)
    else $error("error result with nonzero code point");

  // A legal result never lies above the Unicode range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !illegal |-> code_point <= CP_MAX)
    else $error("code point above range");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind utf8_to_code_point_decoder utf8d_chk u_utf8d_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_byte    (in_byte),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .code_point (code_point),
  .illegal    (illegal)
);

// ===== tb/sv/utf8_to_code_point_decoder_test.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_test
// Self-checking testbench for the UTF-8 to code point decoder. A directed
// table covers byte extremes, each sequence length and every error class,
// and then random text is sent. Most of it is well-formed characters, with
// some overlong, out-of-range, truncated and noise bytes mixed in. A
// behavioral decoder predicts each result, and both channels stall at random.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_test;
  import utf8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Payload bits of a continuation byte once its marker has been removed.
  localparam logic [BYTE_W-1:0] CONT_BITS_MAX = 8'h3F;

  localparam int TEXT_BYTES   = 600;     // Random bytes sent after the table.
  localparam int HOLD_CYCLES  = 300;     // Long receiver hold-off.
  localparam int DRAIN_CYCLES = 40;      // Quiet time after the last result.
  localparam int CYCLE_LIMIT  = 300000;  // Watchdog.
  localparam int PRINT_LIMIT  = 40;      // Mismatch lines printed at most.

  // Idling styles that either side can be in.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_FULL = 1;
  localparam int IDLE_RARE = 2;

  // One decoded character as it shows on the output ports.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            illegal;
  } char_t;

  // One row of the directed table. When typed is set, the row carries its
  // own expectation (emits says whether a result is due at all). When it is
  // clear, the behavioral decoder decides.
  typedef struct packed {
    logic [BYTE_W-1:0] in_b;
    logic              typed;
    logic              emits;
    logic [CP_W-1:0]   cp;
    logic              bad;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Single bytes while idle: lowest and highest ASCII, a stray
    // continuation, the lowest invalid lead and the all-ones byte.
    '{8'h00, 1'b1, 1'b1, 21'h000000, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0},
    '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b1},
    '{8'hF5, 1'b1, 1'b1, 21'h000000, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 21'h000000, 1'b1},
    // Smallest legal two-byte character; the lead itself gives nothing.
    '{8'hC2, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
    // Overlong two-byte form of NUL.
    '{8'hC0, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b1},
    // Overlong four-byte form.
    '{8'hF0, 1'b1, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b1},
    // Top of Unicode.
    '{8'hF4, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'hBF, 1'b1, 1'b1, 21'h10FFFF, 1'b0},
    // One past the top of Unicode.
    '{8'hF4, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h90, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b1, 1'b1, 21'h000000, 1'b1},
    // A surrogate goes through as an ordinary character.
    '{8'hED, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
    // A broken sequence: the ASCII byte ends it with an error and is
    // swallowed, so no second result follows for it.
    '{8'hE2, 1'b0, 1'b0, 21'h000000, 1'b0},
    '{8'h41, 1'b1, 1'b1, 21'h000000, 1'b1}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CP_W-1:0]   code_point;
  logic              illegal;

  // Sideband that travels with each offered byte and tells the monitor
  // whether a typed expectation replaces the predicted one.
  logic  row_typed = 1'b0;
  logic  row_emits = 1'b0;
  char_t row_char  = '0;

  // State of the behavioral decoder.
  logic [1:0]      seq_left = 2'd0;
  logic [CP_W-1:0] seq_bits = '0;
  seq_len_t        seq_len  = SEQ_NONE;

  char_t             pending_chars[$];   // Characters due on the output.
  logic [BYTE_W-1:0] text_bytes[$];      // Bytes of the text piece being sent.

  int  fail_count = 0;
  int  cycle_count = 0;
  int  tx_mode = IDLE_FULL;
  int  rx_mode = IDLE_FULL;
  bit  rx_hold_req = 1'b0;

  utf8_to_code_point_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .illegal    (illegal)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line, up to a limit, and counts every one.
  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Wait time drawn for one item, in cycles, according to the idling style.
  function automatic int draw_wait(input int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 17);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // Advances the behavioral decoder by one byte. Sets emits when the byte
  // completes a character or reveals an error, and returns that result.
  task automatic decode_step(input logic [BYTE_W-1:0] b, output logic emits,
                             output char_t ch);
    logic [BYTE_W-1:0] t;
    logic              bad;
    emits = 1'b0;
    ch    = '0;
    if (seq_left == 2'd0) begin
      // Idle: the byte is a lead, ASCII or garbage.
      if (b < ASCII_LIMIT) begin
        emits = 1'b1;
        ch.code_point = CP_W'(b);
      end else if (b < LEAD2_MIN) begin
        emits = 1'b1;
        ch.illegal = 1'b1;
      end else if (b < LEAD3_MIN) begin
        seq_bits = CP_W'(b[4:0]);
        seq_len  = SEQ_TWO;
        seq_left = 2'd1;
      end else if (b < LEAD4_MIN) begin
        seq_bits = CP_W'(b[3:0]);
        seq_len  = SEQ_THREE;
        seq_left = 2'd2;
      end else if (b <= LEAD4_MAX) begin
        seq_bits = CP_W'(b[2:0]);
        seq_len  = SEQ_FOUR;
        seq_left = 2'd3;
      end else begin
        emits = 1'b1;
        ch.illegal = 1'b1;
      end
    end else begin
      t = b ^ CONT_MARK;
      if (t > CONT_BITS_MAX) begin
        // Not a continuation: drop the sequence and swallow the byte.
        seq_left   = 2'd0;
        seq_bits   = '0;
        seq_len    = SEQ_NONE;
        emits      = 1'b1;
        ch.illegal = 1'b1;
      end else begin
        seq_bits = {seq_bits[CP_W-7:0], t[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          case (seq_len)
            SEQ_TWO:   bad = seq_bits < MIN_TWO;
            SEQ_THREE: bad = seq_bits < MIN_THREE;
            default:   bad = (seq_bits < MIN_FOUR) || (seq_bits > CP_MAX);
          endcase
          emits         = 1'b1;
          ch.illegal    = bad;
          ch.code_point = bad ? '0 : seq_bits;
          seq_bits      = '0;
          seq_len       = SEQ_NONE;
        end
      end
    end
  endtask

  // Appends the UTF-8 form of cp with the given length to text_bytes. Any
  // value is encoded, so short values with long lengths give overlong forms.
  task automatic encode_char(input logic [CP_W-1:0] cp, input int len);
    case (len)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: text_bytes.push_back({3'b110, cp[10:6]});
      3: text_bytes.push_back({4'b1110, cp[15:12]});
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
      end
    endcase
    if (len >= 3) text_bytes.push_back({2'b10, cp[11:6]});
    if (len >= 2) text_bytes.push_back({2'b10, cp[5:0]});
  endtask

  // Fills text_bytes with one random piece of text: mostly legal characters
  // of every length, and now and then an overlong or out-of-range character,
  // a sequence cut short by a foreign byte, or plain noise.
  task automatic build_text;
    int                kind;
    int                len;
    int                keep;
    logic [CP_W-1:0]   floor_cp;
    logic [BYTE_W-1:0] b;
    text_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      encode_char(CP_W'($urandom_range(0, 'h7F)), 1);
    end else if (kind < 50) begin
      encode_char(CP_W'($urandom_range('h80, 'h7FF)), 2);
    end else if (kind < 70) begin
      encode_char(CP_W'($urandom_range('h800, 'hFFFF)), 3);
    end else if (kind < 85) begin
      encode_char(CP_W'($urandom_range('h10000, 'h10FFFF)), 4);
    end else if (kind < 89) begin
      len = $urandom_range(2, 4);
      floor_cp = (len == 2) ? MIN_TWO : (len == 3) ? MIN_THREE : MIN_FOUR;
      encode_char(CP_W'($urandom_range(0, floor_cp - 1)), len);
    end else if (kind < 92) begin
      encode_char(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
    end else if (kind < 96) begin
      len  = $urandom_range(2, 4);
      keep = $urandom_range(1, len - 1);
      encode_char(CP_W'($urandom_range(MIN_FOUR, CP_MAX)), len);
      while (text_bytes.size() > keep) void'(text_bytes.pop_back());
      b = BYTE_W'($urandom_range(0, 255));
      while (b[7:6] == 2'b10) b = BYTE_W'($urandom_range(0, 255));
      text_bytes.push_back(b);
    end else begin
      repeat ($urandom_range(1, 3)) text_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Offers one byte and returns once it has been taken. It is called just
  // after the clock rises. After a gap valid is dropped first; with no gap it
  // stays high so that items follow without a break.
  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic typed,
                            input logic emits, input char_t ch);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    row_typed <= typed;
    row_emits <= emits;
    row_char  <= ch;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Input and output monitor. Both look at values from before the edge, so
  // the order against the block's own updates does not matter.
  always @(posedge clk) begin : monitor
    logic  emits;
    char_t ch;
    char_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        decode_step(in_byte, emits, ch);
        // The predictor always runs to keep its state, but a typed table
        // row overrides its result.
        if (row_typed) begin
          emits = row_emits;
          ch    = row_char;
        end
        if (emits) pending_chars.push_back(ch);
      end
      if (out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected result code_point=%h illegal=%b",
                                    code_point, illegal));
        end else begin
          want = pending_chars.pop_front();
          if (code_point !== want.code_point) begin
            report_mismatch($sformatf("code_point %h, expected %h",
                                      code_point, want.code_point));
          end
          if (illegal !== want.illegal) begin
            report_mismatch($sformatf("illegal %b, expected %b",
                                      illegal, want.illegal));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver. Before each result it draws a number of stall cycles, so that
  // stalls land on any phase of the decoder's work. On request it holds the
  // output for one long stretch, counted here, while the sender keeps going.
  initial begin : receiver
    int wait_cycles;
    do @(posedge clk); while (rst);
    forever begin
      wait_cycles = draw_wait(rx_mode);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Stimulus: reset, the directed table, then random text.
  initial begin : stimulus
    int  sent;
    bit  hold_done;
    bit  pause_done;
    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table, with a mild idling style so it also sees some gaps.
    tx_mode = IDLE_RARE;
    rx_mode = IDLE_RARE;
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_byte(DIRECTED[i].in_b, DIRECTED[i].typed, DIRECTED[i].emits,
                 '{DIRECTED[i].cp, DIRECTED[i].bad});
    end

    // Random text. The idling styles of both sides change now and then,
    // which gives stretches with no idling as well as heavy ones.
    while (sent < TEXT_BYTES) begin
      if ($urandom_range(0, 39) == 0) begin
        tx_mode = $urandom_range(IDLE_NONE, IDLE_RARE);
        rx_mode = $urandom_range(IDLE_NONE, IDLE_RARE);
      end

      // Once, let the receiver hold off while the sender pushes at full
      // rate, so that the decoder fills up and stalls its input.
      if (!hold_done && sent >= 150) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_mode     = IDLE_NONE;
      end

      // Once, stop sending until every expected character has arrived.
      if (!pause_done && sent >= 400) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
      end

      build_text();
      foreach (text_bytes[i]) begin
        offer_byte(text_bytes[i], 1'b0, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Let every expected character arrive, then wait a little longer in
    // case the decoder produces something it should not.
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
